// ===== rtl/aes128_cbc_encrypt_assert.svh =====
// Assertion macros shared by the AES-128 CBC encryptor modules.
// Depends on nothing; define NO_ASSERTIONS to compile them out.
`ifndef AES128_CBC_ENCRYPT_ASSERT_SVH
`define AES128_CBC_ENCRYPT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/aes_cbc_pkg.sv =====
// Types, constants and byte functions for the AES-128 CBC encryptor.
// Used by every module of the block; depends on nothing.
package aes_cbc_pkg;

    localparam int unsigned NUM_ROUNDS = 10;
    localparam int unsigned ROUND_W    = 4;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned FIFO_DEPTH = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_HIGH = 2'd0,
        REG_KEY_LOW  = 2'd1,
        REG_IV_HIGH  = 2'd2,
        REG_IV_LOW   = 2'd3
    } cfg_reg_t;

    localparam logic [7:0] XTIME_POLY = 8'h1b;
    localparam logic [7:0] RCON_FIRST = 8'h01;

    typedef struct packed {
        logic [63:0] plain_high;
        logic [63:0] plain_low;
        logic        chain_start;
    } in_word_t;

    typedef struct packed {
        logic [63:0] cipher_high;
        logic [63:0] cipher_low;
    } out_word_t;

    // front to back: block already whitened with the IV when chain_start
    typedef struct packed {
        logic [127:0] data;
        logic         from_iv;
    } job_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] r;
        case (a)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
            default: r=8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? XTIME_POLY : 8'h00);
    endfunction

    // byte i of a 128-bit value sits at bits [127-8i -: 8]
    function automatic logic [7:0] byte_at(input logic [127:0] s, input int i);
        return s[127-8*i -: 8];
    endfunction

    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127-8*(c*4+r) -: 8] = sbox(byte_at(s, ((c + r) % 4) * 4 + r));
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0]   a0, a1, a2, a3, all;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            a0  = byte_at(s, c*4);
            a1  = byte_at(s, c*4+1);
            a2  = byte_at(s, c*4+2);
            a3  = byte_at(s, c*4+3);
            all = a0 ^ a1 ^ a2 ^ a3;
            t[127-8*(c*4)   -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
            t[127-8*(c*4+1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
            t[127-8*(c*4+2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
            t[127-8*(c*4+3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
        end
        return t;
    endfunction

    function automatic logic [127:0] next_round_key(input logic [127:0] k,
                                                    input logic [7:0] rcon);
        logic [31:0]  w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t  = {sbox(w3[23:16]) ^ rcon, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

// ===== rtl/aes128_cbc_encrypt.sv =====
// AES-128 CBC encryptor. A new block is taken only once the previous one is
// in the result register, set by the single shared round unit (one round per
// cycle, last round held while the result register is full) and the CBC
// chaining loop. rst_n asynchronously zeroes key, IV and chaining value and
// empties all queues. Depends on aes_cbc_pkg, aes_cbc_front and aes_cbc_core.
module aes128_cbc_encrypt (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  aes_cbc_pkg::in_word_t  in_word,
    output logic                   empty,
    input  logic                   pop,
    output aes_cbc_pkg::out_word_t out_word,
    input  logic                   cfg_we,
    input  logic [aes_cbc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]            cfg_data
);

    logic [63:0]       key_high_reg, key_low_reg, iv_high_reg, iv_low_reg;
    logic              job_valid, job_take;
    aes_cbc_pkg::job_t job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            iv_high_reg  <= '0;
            iv_low_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (aes_cbc_pkg::cfg_reg_t'(cfg_index))
                aes_cbc_pkg::REG_KEY_HIGH: key_high_reg <= cfg_data;
                aes_cbc_pkg::REG_KEY_LOW:  key_low_reg  <= cfg_data;
                aes_cbc_pkg::REG_IV_HIGH:  iv_high_reg  <= cfg_data;
                aes_cbc_pkg::REG_IV_LOW:   iv_low_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    aes_cbc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_word   (in_word),
        .iv        ({iv_high_reg, iv_low_reg}),
        .job_valid (job_valid),
        .job       (job),
        .job_take  (job_take)
    );

    aes_cbc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .key       ({key_high_reg, key_low_reg}),
        .job_valid (job_valid),
        .job       (job),
        .job_take  (job_take),
        .empty     (empty),
        .pop       (pop),
        .out_word  (out_word)
    );

endmodule

// ===== rtl/aes_cbc_front.sv =====
// Front end: input queue word capture, IV whitening and a two-entry job queue.
// Depends on aes_cbc_pkg.
module aes_cbc_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  aes_cbc_pkg::in_word_t in_word,
    input  logic [127:0]          iv,
    output logic                  job_valid,
    output aes_cbc_pkg::job_t     job,
    input  logic                  job_take
);

    aes_cbc_pkg::job_t mem_reg [aes_cbc_pkg::FIFO_DEPTH];
    logic              wr_ptr_reg, rd_ptr_reg;
    logic [1:0]        count_reg, count_next;
    logic              do_push, do_pop;
    logic [127:0]      plain;

    assign full      = (count_reg == 2'(aes_cbc_pkg::FIFO_DEPTH));
    assign job_valid = (count_reg != 2'd0);
    assign job       = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = job_take && job_valid;
    assign plain     = {in_word.plain_high, in_word.plain_low};

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg].from_iv <= in_word.chain_start;
            mem_reg[wr_ptr_reg].data    <= in_word.chain_start ? (plain ^ iv) : plain;
        end
    end

    `include "aes128_cbc_encrypt_assert.svh"
    `ASSERT_IMPL(a_count_range, clk, rst_n, 1'b1, count_reg <= 2'd2, "job queue overflow")
    `ASSERT_NEXT(a_push_grows, clk, rst_n, do_push && !do_pop, count_reg == $past(count_reg) + 2'd1, "push lost")
    `ASSERT_NEXT(a_pop_shrinks, clk, rst_n, do_pop && !do_push, count_reg == $past(count_reg) - 2'd1, "pop lost")

endmodule

// ===== rtl/aes_cbc_core.sv =====
// Back end: iterative AES-128 round engine with CBC chaining and output register.
// Depends on aes_cbc_pkg.
module aes_cbc_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [127:0]           key,
    input  logic                   job_valid,
    input  aes_cbc_pkg::job_t      job,
    output logic                   job_take,
    output logic                   empty,
    input  logic                   pop,
    output aes_cbc_pkg::out_word_t out_word
);

    typedef enum logic { ST_IDLE, ST_RUN } state_t;

    state_t                          state_reg;
    logic [aes_cbc_pkg::ROUND_W-1:0] round_reg;
    logic [127:0]                    st_reg, rk_reg, chain_reg, res_reg;
    logic [7:0]                      rcon_reg;
    logic                            res_valid_reg;
    logic [127:0]                    rk_next, sh, rnd_out, start_blk;
    logic                            last, finish, res_free;

    assign rk_next   = aes_cbc_pkg::next_round_key(rk_reg, rcon_reg);
    assign sh        = aes_cbc_pkg::sub_shift(st_reg);
    assign last      = (round_reg == aes_cbc_pkg::ROUND_W'(aes_cbc_pkg::NUM_ROUNDS));
    assign rnd_out   = (last ? sh : aes_cbc_pkg::mix_columns(sh)) ^ rk_next;
    assign finish    = (state_reg == ST_RUN) && last;
    assign res_free  = !res_valid_reg || pop;
    assign job_take  = (state_reg == ST_IDLE) && job_valid;
    assign start_blk = (job.from_iv ? job.data : (job.data ^ chain_reg)) ^ key;
    assign empty     = !res_valid_reg;
    assign out_word  = '{cipher_high: res_reg[127:64], cipher_low: res_reg[63:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            round_reg     <= '0;
            res_valid_reg <= 1'b0;
            chain_reg     <= '0;
        end
        else
        begin
            if (pop && res_valid_reg && !(finish && res_free))
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (job_valid)
                    begin
                        state_reg <= ST_RUN;
                        round_reg <= aes_cbc_pkg::ROUND_W'(1);
                    end
                end
                ST_RUN:
                begin
                    if (!last)
                    begin
                        round_reg <= round_reg + aes_cbc_pkg::ROUND_W'(1);
                    end
                    else if (res_free)
                    begin
                        res_valid_reg <= 1'b1;
                        chain_reg     <= rnd_out;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_take)
        begin
            st_reg   <= start_blk;
            rk_reg   <= key;
            rcon_reg <= aes_cbc_pkg::RCON_FIRST;
        end
        else if ((state_reg == ST_RUN) && !last)
        begin
            st_reg   <= rnd_out;
            rk_reg   <= rk_next;
            rcon_reg <= aes_cbc_pkg::xtime(rcon_reg);
        end
        if (finish && res_free)
        begin
            res_reg <= rnd_out;
        end
    end

    `include "aes128_cbc_encrypt_assert.svh"
    `ASSERT_IMPL(a_take_idle, clk, rst_n, job_take, state_reg == ST_IDLE, "take while busy")
    `ASSERT_NEXT(a_chain_out, clk, rst_n, finish && res_free, res_valid_reg && (chain_reg == res_reg), "chain mismatch")
    `ASSERT_NEXT(a_hold_result, clk, rst_n, res_valid_reg && !pop, res_valid_reg && $stable(res_reg), "result dropped")

endmodule

// ===== tb/sv/aes128_cbc_encrypt_tb.sv =====
// Self-checking bench for the AES-128 CBC encryptor: directed vectors, then random chains
// with random key and IV phases, queue-side stalls and backpressure.
// Depends on aes_cbc_pkg and aes128_cbc_encrypt.
module aes128_cbc_encrypt_tb;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 30;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    aes_cbc_pkg::in_word_t  in_word;
    logic        empty;
    logic        pop;
    aes_cbc_pkg::out_word_t out_word;
    logic        cfg_we;
    logic [aes_cbc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [63:0] cfg_data;

    aes128_cbc_encrypt dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_word(in_word),
        .empty(empty), .pop(pop), .out_word(out_word),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    logic [7:0]   sbox_tbl [256];
    logic [127:0] key_reg;
    logic [127:0] iv_reg;
    logic [127:0] chain_reg;
    aes_cbc_pkg::out_word_t cipher_q[$];
    int           errors;
    int           words_sent;
    int           words_checked;
    int           rx_hold_len;
    bit           no_idle;
    int           idle_cycles;
    int           rx_gap;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [7:0] xt(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[0])
                p = p ^ a;
            a = xt(a);
            b = b >> 1;
        end
        return p;
    endfunction

    task automatic build_sbox();
        logic [7:0] inv;
        for (int a = 0; a < 256; a++)
        begin
            inv = 8'h00;
            for (int b = 1; b < 256; b++)
                if (a != 0 && gmul(a[7:0], b[7:0]) == 8'h01)
                    inv = b[7:0];
            sbox_tbl[a] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                        ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
        end
    endtask

    function automatic logic [7:0] bt(input logic [127:0] s, input int i);
        return s[127-8*i -: 8];
    endfunction

    function automatic logic [127:0] aes_encrypt(input logic [127:0] blk,
                                                 input logic [127:0] key);
        logic [127:0] s, t, rk;
        logic [31:0]  w3, tw;
        logic [7:0]   rcon, a0, a1, a2, a3, all;
        rk   = key;
        rcon = 8'h01;
        s    = blk ^ rk;
        for (int r = 1; r <= 10; r++)
        begin
            for (int c = 0; c < 4; c++)
                for (int w = 0; w < 4; w++)
                    t[127-8*(c*4+w) -: 8] = sbox_tbl[bt(s, ((c + w) & 3) * 4 + w)];
            s = t;
            if (r < 10)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0  = bt(s, c*4);
                    a1  = bt(s, c*4+1);
                    a2  = bt(s, c*4+2);
                    a3  = bt(s, c*4+3);
                    all = a0 ^ a1 ^ a2 ^ a3;
                    t[127-8*(c*4)   -: 8] = a0 ^ all ^ xt(a0 ^ a1);
                    t[127-8*(c*4+1) -: 8] = a1 ^ all ^ xt(a1 ^ a2);
                    t[127-8*(c*4+2) -: 8] = a2 ^ all ^ xt(a2 ^ a3);
                    t[127-8*(c*4+3) -: 8] = a3 ^ all ^ xt(a3 ^ a0);
                end
                s = t;
            end
            w3 = rk[31:0];
            tw = {sbox_tbl[w3[23:16]] ^ rcon, sbox_tbl[w3[15:8]],
                  sbox_tbl[w3[7:0]], sbox_tbl[w3[31:24]]};
            rk[127:96] = rk[127:96] ^ tw;
            rk[95:64]  = rk[95:64] ^ rk[127:96];
            rk[63:32]  = rk[63:32] ^ rk[95:64];
            rk[31:0]   = rk[31:0] ^ rk[63:32];
            rcon = xt(rcon);
            s = s ^ rk;
        end
        return s;
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic write_reg(input aes_cbc_pkg::cfg_reg_t idx, input logic [63:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            aes_cbc_pkg::REG_KEY_HIGH: key_reg[127:64] = val;
            aes_cbc_pkg::REG_KEY_LOW:  key_reg[63:0]   = val;
            aes_cbc_pkg::REG_IV_HIGH:  iv_reg[127:64]  = val;
            aes_cbc_pkg::REG_IV_LOW:   iv_reg[63:0]    = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_key_iv(input logic [127:0] key, input logic [127:0] iv);
        write_reg(aes_cbc_pkg::REG_KEY_HIGH, key[127:64]);
        write_reg(aes_cbc_pkg::REG_KEY_LOW, key[63:0]);
        write_reg(aes_cbc_pkg::REG_IV_HIGH, iv[127:64]);
        write_reg(aes_cbc_pkg::REG_IV_LOW, iv[63:0]);
    endtask

    task automatic wait_drained();
        while (cipher_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_block(input logic [127:0] plain, input logic start);
        aes_cbc_pkg::in_word_t  w;
        aes_cbc_pkg::out_word_t exp;
        logic [127:0] ct;
        int gap;
        w.plain_high  = plain[127:64];
        w.plain_low   = plain[63:0];
        w.chain_start = start;
        push    <= 1'b1;
        in_word <= w;
        do
            @(posedge clk);
        while (full);
        ct = aes_encrypt(plain ^ (start ? iv_reg : chain_reg), key_reg);
        chain_reg = ct;
        exp.cipher_high = ct[127:64];
        exp.cipher_low  = ct[63:0];
        cipher_q.push_back(exp);
        words_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic end_burst();
        push <= 1'b0;
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        aes_cbc_pkg::out_word_t exp;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                words_checked++;
                if (cipher_q.size() == 0)
                begin
                    $display("%0t: unexpected word %h", $time, out_word);
                    errors++;
                end
                else
                begin
                    exp = cipher_q.pop_front();
                    if (out_word.cipher_high !== exp.cipher_high)
                    begin
                        $display("%0t: cipher_high expected %h actual %h",
                                 $time, exp.cipher_high, out_word.cipher_high);
                        errors++;
                    end
                    if (out_word.cipher_low !== exp.cipher_low)
                    begin
                        $display("%0t: cipher_low expected %h actual %h",
                                 $time, exp.cipher_low, out_word.cipher_low);
                        errors++;
                    end
                end
                rx_gap = pick_gap();
            end
            if (rx_hold_len > 0)
            begin
                pop <= 1'b0;
                rx_hold_len--;
            end
            else if (rx_gap > 0)
            begin
                pop <= 1'b0;
                rx_gap--;
            end
            else
                pop <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d words outstanding", $time, cipher_q.size());
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic test_reset_chain();
        send_block('0, 1'b0);
        send_block('1, 1'b0);
        send_block('0, 1'b1);
        end_burst();
        wait_drained();
    endtask

    task automatic test_known_vector();
        logic [127:0] ct;
        set_key_iv(128'h000102030405060708090a0b0c0d0e0f, '0);
        ct = aes_encrypt(128'h00112233445566778899aabbccddeeff, key_reg);
        if (ct !== 128'h69c4e0d86a7b0430d8cdb78070b4c55a)
        begin
            $display("%0t: predictor vector expected %h actual %h", $time,
                     128'h69c4e0d86a7b0430d8cdb78070b4c55a, ct);
            errors++;
        end
        send_block(128'h00112233445566778899aabbccddeeff, 1'b1);
        send_block(128'h00112233445566778899aabbccddeeff, 1'b0);
        end_burst();
        wait_drained();
    endtask

    task automatic test_extremes();
        set_key_iv('1, '1);
        send_block('0, 1'b1);
        send_block('1, 1'b0);
        send_block('1, 1'b1);
        send_block('0, 1'b0);
        end_burst();
        wait_drained();
        set_key_iv('0, 128'h8000000000000001_8000000000000001);
        send_block(128'h0123456789abcdef_fedcba9876543210, 1'b1);
        send_block('1, 1'b0);
        end_burst();
        wait_drained();
    endtask

    task automatic test_key_change_midchain();
        set_key_iv({rand64(), rand64()}, {rand64(), rand64()});
        send_block({rand64(), rand64()}, 1'b1);
        send_block({rand64(), rand64()}, 1'b0);
        end_burst();
        wait_drained();
        write_reg(aes_cbc_pkg::REG_KEY_LOW, rand64());
        write_reg(aes_cbc_pkg::REG_IV_HIGH, rand64());
        send_block({rand64(), rand64()}, 1'b0);
        send_block({rand64(), rand64()}, 1'b1);
        end_burst();
        wait_drained();
    endtask

    task automatic test_backpressure();
        rx_hold_len = 400;
        no_idle = 1'b1;
        for (int i = 0; i < 12; i++)
            send_block({rand64(), rand64()}, i == 0);
        no_idle = 1'b0;
        end_burst();
        wait_drained();
    endtask

    task automatic test_random(input int count);
        int run;
        int phase;
        phase = 0;
        run   = 0;
        for (int i = 0; i < count; i++)
        begin
            if (i % 250 == 0)
            begin
                end_burst();
                wait_drained();
                case (phase % 4)
                    0: set_key_iv({rand64(), rand64()}, {rand64(), rand64()});
                    1: set_key_iv('1, '0);
                    2: set_key_iv('0, '1);
                    default: set_key_iv({rand64(), rand64()}, {rand64(), rand64()});
                endcase
                no_idle = (phase % 3 == 2);
                phase++;
            end
            if ($urandom_range(0, 199) == 0)
            begin
                end_burst();
                wait_drained();
            end
            if (run == 0)
                run = $urandom_range(1, 12);
            case ($urandom_range(0, 9))
                0: send_block('0, run == 1);
                1: send_block('1, 1'($urandom_range(0, 1)));
                default: send_block({rand64(), rand64()}, run == 1 || $urandom_range(0, 15) == 0);
            endcase
            run--;
        end
        no_idle = 1'b0;
        end_burst();
        wait_drained();
    endtask

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        push        = 1'b0;
        pop         = 1'b0;
        in_word     = '0;
        cfg_we      = 1'b0;
        cfg_index   = aes_cbc_pkg::REG_KEY_HIGH;
        cfg_data    = '0;
        key_reg     = '0;
        iv_reg      = '0;
        chain_reg   = '0;
        errors      = 0;
        words_sent  = 0;
        words_checked = 0;
        rx_hold_len = 0;
        rx_gap      = 0;
        no_idle     = 1'b0;
        idle_cycles = 0;
        build_sbox();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_chain();
        test_known_vector();
        test_extremes();
        test_key_change_midchain();
        test_backpressure();
        test_random(2000);
        if (cipher_q.size() != 0)
        begin
            $display("%0t: %0d expected words never arrived", $time, cipher_q.size());
            errors++;
        end
        $display("Sent %0d blocks and checked %0d ciphertext words across key/IV phases,",
                 words_sent, words_checked);
        $display("covering chain restarts, chaining after reset, extremes and stalls.");
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/aes_cbc_pkg.sv
rtl/aes_cbc_front.sv
rtl/aes_cbc_core.sv
rtl/aes128_cbc_encrypt.sv
tb/sv/aes128_cbc_encrypt_tb.sv
